// ===== src/crast_pkg.sv =====
package crast_pkg;

	localparam int RADIUS_BITS = 12;
	localparam int COORD_BITS  = 16;

	// Octant walk widths, derived from the radius width (SUM_W also from the coordinate width).
	localparam int XY_W   = RADIUS_BITS + 1;
	localparam int STEP_W = RADIUS_BITS + 2;
	localparam int ERR_W  = RADIUS_BITS + 4;
	localparam int DIAM_W = RADIUS_BITS + 1;
	localparam int SUM_W  = (COORD_BITS > XY_W) ? COORD_BITS : XY_W;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int PTS_PER_STEP = 8;
	localparam int PT_W         = $clog2(PTS_PER_STEP);
	localparam logic [PT_W-1:0] PT_LAST = PT_W'(PTS_PER_STEP - 1);

	// One octant position to be expanded into its eight symmetric points.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic signed [XY_W-1:0]       x;
		logic signed [XY_W-1:0]       y;
		logic                         done;
	} step_rec_t;

endpackage

// ===== src/crast_in_if.sv =====
interface crast_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   command;
	logic signed [crast_pkg::COORD_BITS-1:0] center_x;
	logic signed [crast_pkg::COORD_BITS-1:0] center_y;
	logic [crast_pkg::RADIUS_BITS-1:0]       radius;

	modport source (output valid, command, center_x, center_y, radius, input ready);
	modport sink (input valid, command, center_x, center_y, radius, output ready);
endinterface

// ===== src/crast_out_if.sv =====
interface crast_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [crast_pkg::COORD_BITS-1:0] point_x;
	logic signed [crast_pkg::COORD_BITS-1:0] point_y;
	logic                                   last_of_step;
	logic                                   circle_done;

	modport source (output valid, point_x, point_y, last_of_step, circle_done, input ready);
	modport sink (input valid, point_x, point_y, last_of_step, circle_done, output ready);
endinterface

// ===== src/crast_front.sv =====
module crast_front (
	input  logic                 clk,
	input  logic                 arst_n,
	crast_in_if.sink             cmd,
	input  logic                 q_full,
	output logic                 q_push,
	output crast_pkg::step_rec_t q_rec
);

	logic signed [crast_pkg::XY_W-1:0]       cur_x_q, cur_y_q;
	logic [crast_pkg::STEP_W-1:0]            step_tx_q, step_ty_q;
	logic signed [crast_pkg::ERR_W-1:0]      error_q;
	logic [crast_pkg::DIAM_W-1:0]            diam_q;
	logic signed [crast_pkg::COORD_BITS-1:0] cx_q, cy_q;
	logic                                    active_q;

	logic                                    take;
	logic                                    finished;
	logic                                    do_step;
	logic                                    y_move, x_move;
	logic signed [crast_pkg::ERR_W-1:0]      e1, e2;
	logic signed [crast_pkg::XY_W-1:0]       x1, y1;
	logic [crast_pkg::STEP_W-1:0]            ty1, tx1;
	logic [crast_pkg::DIAM_W-1:0]            start_diam;

	assign cmd.ready = !q_full;
	assign take      = cmd.valid && cmd.ready;
	assign finished  = cur_x_q < cur_y_q;
	assign do_step   = take && (cmd.command == crast_pkg::CMD_STEP) && active_q && !finished;

	always_comb begin
		y_move = (error_q <= 0);
		e1     = y_move ? error_q + $signed(crast_pkg::ERR_W'(step_ty_q)) : error_q;
		y1     = y_move ? cur_y_q + crast_pkg::XY_W'(1) : cur_y_q;
		ty1    = y_move ? step_ty_q + crast_pkg::STEP_W'(2) : step_ty_q;
		x_move = (e1 > 0);
		tx1    = x_move ? step_tx_q + crast_pkg::STEP_W'(2) : step_tx_q;
		x1     = x_move ? cur_x_q - crast_pkg::XY_W'(1) : cur_x_q;
		e2     = x_move ? e1 + $signed(crast_pkg::ERR_W'(tx1))
			- $signed(crast_pkg::ERR_W'(diam_q)) : e1;
		start_diam = {cmd.radius, 1'b0};
	end

	assign q_push       = do_step;
	assign q_rec.cx     = cx_q;
	assign q_rec.cy     = cy_q;
	assign q_rec.x      = cur_x_q;
	assign q_rec.y      = cur_y_q;
	assign q_rec.done   = x1 < y1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			step_tx_q <= crast_pkg::STEP_W'(1);
			step_ty_q <= crast_pkg::STEP_W'(1);
			error_q   <= '0;
			diam_q    <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			active_q  <= 1'b0;
		end else if (take) begin
			if (cmd.command == crast_pkg::CMD_START) begin
				cx_q      <= cmd.center_x;
				cy_q      <= cmd.center_y;
				diam_q    <= start_diam;
				cur_x_q   <= crast_pkg::XY_W'(cmd.radius) - crast_pkg::XY_W'(1);
				cur_y_q   <= '0;
				step_tx_q <= crast_pkg::STEP_W'(1);
				step_ty_q <= crast_pkg::STEP_W'(1);
				error_q   <= crast_pkg::ERR_W'(1) - $signed(crast_pkg::ERR_W'(start_diam));
				active_q  <= (cmd.radius != '0);
			end else if (do_step) begin
				cur_x_q   <= x1;
				cur_y_q   <= y1;
				step_tx_q <= tx1;
				step_ty_q <= ty1;
				error_q   <= e2;
				active_q  <= !(x1 < y1);
			end else begin
				active_q  <= 1'b0;
			end
		end
	end

endmodule

// ===== src/crast_queue.sv =====
module crast_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  crast_pkg::step_rec_t push_rec,
	output logic                 full,
	input  logic                 pop,
	output logic                 avail,
	output crast_pkg::step_rec_t head
);

	crast_pkg::step_rec_t               mem_q [crast_pkg::QUEUE_DEPTH];
	logic [crast_pkg::QPTR_W-1:0]       wr_q, rd_q;
	logic [crast_pkg::QCNT_W-1:0]       cnt_q;

	assign full  = (cnt_q == crast_pkg::QCNT_W'(crast_pkg::QUEUE_DEPTH));
	assign avail = (cnt_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + crast_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + crast_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + crast_pkg::QCNT_W'(push) - crast_pkg::QCNT_W'(pop);
		end
	end

endmodule

// ===== src/crast_back.sv =====
module crast_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 avail,
	input  crast_pkg::step_rec_t head,
	output logic                 pop,
	crast_out_if.source          pix
);

	logic [crast_pkg::PT_W-1:0]        k_q;
	logic                              valid_q;
	logic                              load;
	logic signed [crast_pkg::XY_W-1:0] dx, dy;
	logic signed [crast_pkg::SUM_W-1:0] sx, sy;

	assign load = avail && (!valid_q || pix.ready);
	assign pop  = load && (k_q == crast_pkg::PT_LAST);
	assign pix.valid = valid_q;

	// Pick the symmetric offset for this point.
	always_comb begin
		unique case (k_q)
			3'd0: begin dx = head.x;  dy = -head.y; end
			3'd1: begin dx = head.x;  dy = head.y;  end
			3'd2: begin dx = -head.x; dy = -head.y; end
			3'd3: begin dx = -head.x; dy = head.y;  end
			3'd4: begin dx = head.y;  dy = -head.x; end
			3'd5: begin dx = head.y;  dy = head.x;  end
			3'd6: begin dx = -head.y; dy = -head.x; end
			3'd7: begin dx = -head.y; dy = head.x;  end
		endcase
		sx = crast_pkg::SUM_W'(head.cx) + crast_pkg::SUM_W'(dx);
		sy = crast_pkg::SUM_W'(head.cy) + crast_pkg::SUM_W'(dy);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix.point_x      <= sx[crast_pkg::COORD_BITS-1:0];
			pix.point_y      <= sy[crast_pkg::COORD_BITS-1:0];
			pix.last_of_step <= (k_q == crast_pkg::PT_LAST);
			pix.circle_done  <= head.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q     <= k_q + crast_pkg::PT_W'(1);
				valid_q <= 1'b1;
			end else if (pix.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/midpoint_circle_rasterizer.sv =====
// An accepted step item is written into the step queue, and its first point is then
// registered into the output register; earlier queued steps or output back-pressure can hold it.
// Throughput: one point per cycle from the output register while pix.ready is high;
// a start item yields no point.
// The two-entry step queue sets how far the command side runs ahead.
// Reset (arst_n low, asynchronous) drops any running circle and empties the queue.
module midpoint_circle_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	crast_in_if.sink    cmd,
	crast_out_if.source pix
);

	crast_pkg::step_rec_t push_rec;
	crast_pkg::step_rec_t head;
	logic                 push, full, pop, avail;

	// Front: accept commands, walk the octant, queue one record per live step.
	crast_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.q_full (full),
		.q_push (push),
		.q_rec  (push_rec)
	);

	// Decouple the command walk from the point output.
	crast_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.avail    (avail),
		.head     (head)
	);

	// Back: expand each record into eight points, one per cycle while the output is not stalled.
	crast_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.head   (head),
		.pop    (pop),
		.pix    (pix)
	);

endmodule
